@@ sv/umep_pkg.sv @@
package umep_pkg;

   // ring geometry
   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   // configuration port
   localparam int CABLE_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CABLE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_CABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK  = 1'd1;

   // item actions
   localparam logic ACT_RECEIVE = 1'b0;
   localparam logic ACT_EMIT    = 1'b1;

   // midi status bytes
   localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
   localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
   localparam logic [7:0] MIDI_CLOCK       = 8'hF8;
   localparam logic [7:0] MIDI_TUNE_REQ    = 8'hF6;
   localparam logic [7:0] MIDI_SONG_POS    = 8'hF2;
   localparam logic [7:0] MIDI_TIME_CODE   = 8'hF1;
   localparam logic [7:0] MIDI_SONG_SEL    = 8'hF3;

   // code index numbers
   localparam logic [3:0] CIN_MISC      = 4'h0;
   localparam logic [3:0] CIN_CABLE_EVT = 4'h1;
   localparam logic [3:0] CIN_SYS_2B    = 4'h2;
   localparam logic [3:0] CIN_SYS_3B    = 4'h3;
   localparam logic [3:0] CIN_SYSEX     = 4'h4;
   localparam logic [3:0] CIN_END_1B    = 4'h5;
   localparam logic [3:0] CIN_END_2B    = 4'h6;
   localparam logic [3:0] CIN_END_3B    = 4'h7;
   localparam logic [3:0] CIN_PROG_CHG  = 4'hC;
   localparam logic [3:0] CIN_CHAN_PRES = 4'hD;
   localparam logic [3:0] CIN_SINGLE    = 4'hF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_CLASSIFY,
      S_READ_X,
      S_LOAD,
      S_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      KIND_MSG,
      KIND_SYSEX,
      KIND_STRAY
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] cin;
      logic [1:0] extra;
      logic       sysex_start;
   } cls_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic       rd_en;
      logic       cls_load;
      logic       load_en;
      logic       load_third;
      logic       chunk;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] recv_count;
      logic       emit_ok;
      cls_type    cls;
      logic       cur_eox;
      logic       out_free;
   } sts_type;

   // bytes pushed for a received packet, zero when dropped
   function automatic logic [1:0] recv_count(input logic [3:0] cin);
      logic [1:0] n;
      n = 2'd3;
      if (cin == CIN_MISC || cin == CIN_CABLE_EVT) begin
         n = 2'd0;
      end else if (cin == CIN_END_1B || cin == CIN_SINGLE) begin
         n = 2'd1;
      end else if (cin == CIN_SYS_2B || cin == CIN_END_2B ||
                   cin == CIN_PROG_CHG || cin == CIN_CHAN_PRES) begin
         n = 2'd2;
      end
      return n;
   endfunction

   // sort the first byte of a message
   function automatic cls_type classify(input logic [7:0] b, input logic sysex);
      cls_type c;
      c.kind        = KIND_STRAY;
      c.cin         = CIN_MISC;
      c.extra       = 2'd0;
      c.sysex_start = 1'b0;
      if (b[7:4] >= 4'h8 && b[7:4] <= 4'hE) begin
         c.kind  = KIND_MSG;
         c.cin   = b[7:4];
         c.extra = (b[7:4] == CIN_PROG_CHG || b[7:4] == CIN_CHAN_PRES) ? 2'd1 : 2'd2;
      end else if (b == MIDI_TIME_CODE || b == MIDI_SONG_SEL) begin
         c.kind  = KIND_MSG;
         c.cin   = CIN_SYS_2B;
         c.extra = 2'd1;
      end else if (b == MIDI_TUNE_REQ || b >= MIDI_CLOCK) begin
         c.kind  = KIND_MSG;
         c.cin   = CIN_END_1B;
      end else if (b == MIDI_SONG_POS) begin
         c.kind  = KIND_MSG;
         c.cin   = CIN_SYS_3B;
         c.extra = 2'd2;
      end else if (!sysex && b == MIDI_SYSEX_START) begin
         c.kind        = KIND_MSG;
         c.cin         = CIN_SYSEX;
         c.extra       = 2'd2;
         c.sysex_start = 1'b1;
      end else if (sysex) begin
         c.kind = KIND_SYSEX;
         c.cin  = (b == MIDI_SYSEX_END) ? CIN_END_1B : CIN_MISC;
      end
      return c;
   endfunction

endpackage

@@ sv/usb_midi_event_packetizer.sv @@
// usb-midi event packetizer
// req channel: one item per transfer. req_action selects receive (pack a
// 4-byte event packet's midi bytes into the byte ring) or emit (pop one
// midi message from the ring and return it as an event packet).
// rsp channel: one event packet per transfer, only for emits that find a
// message; dropped packets, stray bytes, an empty ring or an unconfigured
// link give no transfer.
// csr port: index 0 sets the virtual cable, index 1 the link-configured
// flag; write only while the block is idle.
// timing: one item at a time. a receive captures the packet in idle, then
// writes each pushed byte (up to 3) to the ring. an emit reads the first
// byte from the ring and classifies it, then reads and loads each further
// byte of the message, and last loads the result register. the single
// ring port, one byte a cycle with registered read, keeps these steps apart.
// req_stall is low only while idle; a new request is taken while a
// result still waits in the output register.
// reset clears pointers, the sysex flag, configuration and the entry valid
// bits, so the ring reads as all zero; no clearing pass is needed.
// a stalled receiver holds the result; an emit that completes meanwhile
// waits in its last step until the register frees up.
module usb_midi_event_packetizer
   import umep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [7:0]            req_packet_header,
   input  logic [7:0]            req_packet_byte1,
   input  logic [7:0]            req_packet_byte2,
   input  logic [7:0]            req_packet_byte3,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_event_header,
   output logic [7:0]            rsp_event_byte1,
   output logic [7:0]            rsp_event_byte2,
   output logic [7:0]            rsp_event_byte3
);

   cmd_type cmd;
   sts_type sts;

   umep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   umep_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_packet_header (req_packet_header),
      .req_packet_byte1  (req_packet_byte1),
      .req_packet_byte2  (req_packet_byte2),
      .req_packet_byte3  (req_packet_byte3),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_header  (rsp_event_header),
      .rsp_event_byte1   (rsp_event_byte1),
      .rsp_event_byte2   (rsp_event_byte2),
      .rsp_event_byte3   (rsp_event_byte3),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

@@ sv/umep_ctrl.sv @@
module umep_ctrl
   import umep_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_action,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic       slot_ff, slot_in;
   logic       chunk_ff, chunk_in;

   // state and sequencing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 2'd0;
         sel_ff   <= 2'd0;
         slot_ff  <= 1'b0;
         chunk_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         slot_ff  <= slot_in;
         chunk_ff <= chunk_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sel_in    = sel_ff;
      slot_in   = slot_ff;
      chunk_in  = chunk_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.wr_sel     = sel_ff;
      cmd.load_third = slot_ff;
      cmd.chunk      = chunk_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == ACT_EMIT) begin
                  if (sts.emit_ok) begin
                     state_in = S_READ;
                  end
               end else if (sts.recv_count != 2'd0) begin
                  cmd.capture = 1'b1;
                  cnt_in      = sts.recv_count;
                  sel_in      = 2'd0;
                  state_in    = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            cmd.wr_en = 1'b1;
            if (cnt_ff == 2'd1) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff - 2'd1;
               sel_in = sel_ff + 2'd1;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CLASSIFY;
         end
         S_CLASSIFY: begin
            cmd.cls_load = 1'b1;
            slot_in      = 1'b0;
            unique case (sts.cls.kind)
               KIND_MSG: begin
                  chunk_in = 1'b0;
                  cnt_in   = sts.cls.extra;
                  state_in = (sts.cls.extra == 2'd0) ? S_OUTPUT : S_READ_X;
               end
               KIND_SYSEX: begin
                  chunk_in = 1'b1;
                  state_in = sts.cur_eox ? S_OUTPUT : S_READ_X;
               end
               KIND_STRAY: begin
                  state_in = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_READ_X: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_en = 1'b1;
            if (chunk_ff) begin
               if (sts.cur_eox || slot_ff) begin
                  state_in = S_OUTPUT;
               end else begin
                  slot_in  = 1'b1;
                  state_in = S_READ_X;
               end
            end else if (cnt_ff == 2'd1) begin
               state_in = S_OUTPUT;
            end else begin
               cnt_in   = cnt_ff - 2'd1;
               slot_in  = 1'b1;
               state_in = S_READ_X;
            end
         end
         S_OUTPUT: begin
            // wait for the result register to free up
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/umep_datapath.sv @@
module umep_datapath
   import umep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [7:0]            req_packet_header,
   input  logic [7:0]            req_packet_byte1,
   input  logic [7:0]            req_packet_byte2,
   input  logic [7:0]            req_packet_byte3,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_event_header,
   output logic [7:0]            rsp_event_byte1,
   output logic [7:0]            rsp_event_byte2,
   output logic [7:0]            rsp_event_byte3,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

   logic [CABLE_W-1:0] cable_ff;
   logic               link_ff;
   logic [RING_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic               sysex_ff;
   logic [7:0]         ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] vld_ff;
   logic [7:0]         rd_data_ff;
   logic               rd_vld_ff;
   logic [7:0]         in1_ff, in2_ff, in3_ff;
   logic [7:0]         pkt1_ff, pkt2_ff, pkt3_ff;
   logic [3:0]         cin_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_hdr_ff, rsp_b1_ff, rsp_b2_ff, rsp_b3_ff;
   logic [7:0]         cur_byte;
   logic [7:0]         wr_byte;
   cls_type            cls;

   function automatic logic [RING_AW-1:0] ptr_next(input logic [RING_AW-1:0] p);
      return (p == RING_LAST) ? '0 : p + 1'b1;
   endfunction

   // never-written entries read as zero
   assign cur_byte = rd_vld_ff ? rd_data_ff : 8'h00;
   assign cls      = classify(cur_byte, sysex_ff);

   always_comb begin
      unique case (cmd.wr_sel)
         2'd0:    wr_byte = in1_ff;
         2'd1:    wr_byte = in2_ff;
         default: wr_byte = in3_ff;
      endcase
   end

   // status to controller
   always_comb begin
      sts.recv_count = (req_packet_header[7:4] == cable_ff) ?
                       recv_count(req_packet_header[3:0]) : 2'd0;
      sts.emit_ok    = link_ff && (rd_ptr_ff != wr_ptr_ff);
      sts.cls        = cls;
      sts.cur_eox    = (cur_byte == MIDI_SYSEX_END);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cable_ff <= '0;
         link_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CABLE: cable_ff <= csr_data[CABLE_W-1:0];
            CSR_LINK:  link_ff  <= csr_data[0];
            default:   link_ff  <= link_ff;
         endcase
      end
   end

   // ring storage, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_mem[wr_ptr_ff] <= wr_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   // pointers, entry valid bits, sysex flag
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         sysex_ff  <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            vld_ff[wr_ptr_ff] <= 1'b1;
            wr_ptr_ff         <= ptr_next(wr_ptr_ff);
         end
         if (cmd.rd_en) begin
            rd_vld_ff <= vld_ff[rd_ptr_ff];
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (cmd.cls_load) begin
            if (cls.sysex_start) begin
               sysex_ff <= 1'b1;
            end else if (cls.kind == KIND_SYSEX && cur_byte == MIDI_SYSEX_END) begin
               sysex_ff <= 1'b0;
            end
         end
         if (cmd.load_en && cmd.chunk && cur_byte == MIDI_SYSEX_END) begin
            sysex_ff <= 1'b0;
         end
      end
   end

   // captured receive bytes
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in1_ff <= req_packet_byte1;
         in2_ff <= req_packet_byte2;
         in3_ff <= req_packet_byte3;
      end
   end

   // packet assembly
   always_ff @(posedge clock) begin
      if (cmd.cls_load) begin
         pkt1_ff <= cur_byte;
         pkt2_ff <= 8'h00;
         pkt3_ff <= 8'h00;
         cin_ff  <= cls.cin;
      end else if (cmd.load_en) begin
         if (cmd.load_third) begin
            pkt3_ff <= cur_byte;
         end else begin
            pkt2_ff <= cur_byte;
         end
         if (cmd.chunk) begin
            if (cur_byte == MIDI_SYSEX_END) begin
               cin_ff <= cmd.load_third ? CIN_END_3B : CIN_END_2B;
            end else if (cmd.load_third) begin
               cin_ff <= CIN_SYSEX;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hdr_ff <= {cable_ff, cin_ff};
         rsp_b1_ff  <= pkt1_ff;
         rsp_b2_ff  <= pkt2_ff;
         rsp_b3_ff  <= pkt3_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_header = rsp_hdr_ff;
   assign rsp_event_byte1  = rsp_b1_ff;
   assign rsp_event_byte2  = rsp_b2_ff;
   assign rsp_event_byte3  = rsp_b3_ff;

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // the ring is never written and read in the same cycle
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.rd_en))
      else $error("ring write and read in one cycle");

   // a written entry is marked valid
   a_mark_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |=> vld_ff[$past(wr_ptr_ff)])
      else $error("written ring entry not marked valid");

endmodule
